/* rtl/core/cic_grid_interpolate_deposit_macros.svh */
// Assertion macros shared by the grid interpolate and deposit RTL.
`ifndef CIC_GRID_INTERPOLATE_DEPOSIT_MACROS_SVH
`define CIC_GRID_INTERPOLATE_DEPOSIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define CGID_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define CGID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CGID_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define CGID_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* rtl/core/cgid_pkg.sv */
// Types and constants for the grid interpolate and deposit block.
`timescale 1ns / 1ps
package cgid_pkg;

  localparam int CFG_CNT_W  = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int ADDR_IN_W  = 15;
  localparam int COORD_W    = 32;
  localparam int VAL_W      = 32;
  localparam int REQ_W      = 2;
  localparam int STAT_W     = 2;
  localparam int IN_TDATA_W = 144;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE   = 2'd0,
    REQ_READ    = 2'd1,
    REQ_INTERP  = 2'd2,
    REQ_DEPOSIT = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_OUTSIDE   = 2'd1,
    STAT_SATURATED = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIODIC_X = 3'd0,
    CFG_CELLS_X    = 3'd1,
    CFG_CELLS_Y    = 3'd2,
    CFG_PITCH_Z    = 3'd3,
    CFG_INV_X      = 3'd4,
    CFG_INV_Y      = 3'd5,
    CFG_INV_Z      = 3'd6
  } cfg_reg_t;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;
  localparam logic [2:0] CORNER_LAST = 3'd7;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DECODE, ST_WRITE, ST_READ, ST_SPLIT, ST_SPLIT_END,
    ST_CHECK, ST_WEIGHT, ST_SCALE, ST_FETCH, ST_TERM, ST_UPDATE, ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_CLEAR, OP_WRITE, OP_READ, OP_SPLIT, OP_SPLIT_END,
    OP_CHECK, OP_WEIGHT, OP_SCALE, OP_FETCH, OP_TERM, OP_UPDATE, OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] axis;
    logic [2:0] corner;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    req_t req;
    logic ok;
  } sts_t;

endpackage

/* rtl/core/cic_grid_interpolate_deposit.sv */
// Top level of the 3D grid interpolate and cloud-in-cell deposit unit.
// Input beats on s_axis carry one request: write or read a cell by linear
// address, interpolate the grid at a coordinate, or deposit an amount there.
// Every request gives exactly one beat on m_axis: value in tdata, status in
// tuser (ok, outside grid, saturated deposit).
// Registers are written on the cfg channel (always ready); the user must write
// them only while no request is in flight, which the block does not enforce.
// A write to an index past the list is dropped. Write and read pass through
// decode and a memory access state. Interpolate and deposit run one split
// multiply per axis and a bounds check, then weight, scale, fetch, term and
// update for each of the eight corners; a coordinate outside the grid skips
// the corners. Input is accepted again in the cycle after the result is
// registered. After reset the grid memory is swept to zero, one cell per
// cycle over all MAX_CELLS_X*MAX_CELLS_Y*MAX_PITCH_Z cells (32768 by
// default), with s_axis_tready low; config writes are taken throughout.
// When the receiver stalls, the result holds in the output register and one
// more request may be accepted; that request waits at its end until the
// output beat is taken.
`timescale 1ns / 1ps
`include "cic_grid_interpolate_deposit_macros.svh"
module cic_grid_interpolate_deposit #(
  parameter int MAX_CELLS_X = 32,
  parameter int MAX_CELLS_Y = 32,
  parameter int MAX_PITCH_Z = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cell_addr[14:0], coord_x[46:15], coord_y[78:47], coord_z[110:79],
  // sample_value[142:111], zero pad[143]
  input  logic [143:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_value[31:0]
  output logic [31:0]  m_axis_tdata,
  // status[1:0]
  output logic [1:0]   m_axis_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import cgid_pkg::*;

  cmd_t   cmd;
  sts_t   sts;
  state_t state;
  logic signed [VAL_W-1:0] result_value;
  logic [STAT_W-1:0]       status;

  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = result_value;
  assign m_axis_tuser = status;

  cgid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd),
    .state     (state)
  );

  cgid_dp #(
    .MAX_CELLS_X (MAX_CELLS_X),
    .MAX_CELLS_Y (MAX_CELLS_Y),
    .MAX_PITCH_Z (MAX_PITCH_Z),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_type     (s_axis_tuser),
    .cell_addr    (s_axis_tdata[14:0]),
    .coord_x      (s_axis_tdata[46:15]),
    .coord_y      (s_axis_tdata[78:47]),
    .coord_z      (s_axis_tdata[110:79]),
    .sample_value ($signed(s_axis_tdata[142:111])),
    .result_value (result_value),
    .status       (status)
  );

  // One request in flight at a time.
  `CGID_ASSERT_NEXT(a_one_in_flight, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted twice in a row")
  // Outside-grid results carry a zero value.
  `CGID_ASSERT_IMPLY(a_outside_zero, clk, rst, m_axis_tvalid && (m_axis_tuser == STAT_OUTSIDE), m_axis_tdata == '0, "outside result not zero")
  // No result while the grid is being cleared.
  `CGID_ASSERT_IMPLY(a_clear_quiet, clk, rst, state == ST_CLEAR, !m_axis_tvalid && !s_axis_tready, "activity during clear sweep")

endmodule

/* rtl/core/cgid_ctrl.sv */
// Sequencer for clear, cell access and the eight-corner loop.
`timescale 1ns / 1ps
module cgid_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  cgid_pkg::sts_t  sts,
  output cgid_pkg::cmd_t  cmd,
  output cgid_pkg::state_t state
);
  import cgid_pkg::*;

  state_t     state_next;
  logic [1:0] axis, axis_next;
  logic [2:0] corner, corner_next;
  logic       out_valid_next;
  logic       can_finish;

  assign can_finish = !out_valid || out_ready;

  // Hold state and loop counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      axis      <= AXIS_X;
      corner    <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      axis      <= axis_next;
      corner    <= corner_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state.
  always_comb begin
    state_next  = state;
    axis_next   = axis;
    corner_next = corner;
    case (state)
      ST_CLEAR:  if (sts.clr_done) state_next = ST_IDLE;
      ST_IDLE:   if (in_valid) state_next = ST_DECODE;
      ST_DECODE: begin
        axis_next   = AXIS_X;
        corner_next = '0;
        case (sts.req)
          REQ_WRITE: state_next = ST_WRITE;
          REQ_READ:  state_next = ST_READ;
          default:   state_next = ST_SPLIT;
        endcase
      end
      ST_WRITE:  state_next = ST_FINISH;
      ST_READ:   state_next = ST_FINISH;
      ST_SPLIT: begin
        if (axis == AXIS_Z) state_next = ST_SPLIT_END;
        else axis_next = axis + 2'd1;
      end
      ST_SPLIT_END: state_next = ST_CHECK;
      ST_CHECK:     state_next = ST_WEIGHT;
      ST_WEIGHT:    state_next = sts.ok ? ST_SCALE : ST_FINISH;
      ST_SCALE:     state_next = ST_FETCH;
      ST_FETCH:     state_next = ST_TERM;
      ST_TERM:      state_next = ST_UPDATE;
      ST_UPDATE: begin
        if (corner == CORNER_LAST) begin
          state_next = ST_FINISH;
        end else begin
          corner_next = corner + 3'd1;
          state_next  = ST_WEIGHT;
        end
      end
      ST_FINISH: if (can_finish) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  // Commands and handshakes.
  always_comb begin
    cmd.axis       = axis;
    cmd.corner     = corner;
    cmd.op         = OP_NONE;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_CLEAR:     cmd.op = OP_CLEAR;
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      ST_WRITE:     cmd.op = OP_WRITE;
      ST_READ:      cmd.op = OP_READ;
      ST_SPLIT:     cmd.op = OP_SPLIT;
      ST_SPLIT_END: cmd.op = OP_SPLIT_END;
      ST_CHECK:     cmd.op = OP_CHECK;
      ST_WEIGHT:    cmd.op = OP_WEIGHT;
      ST_SCALE:     cmd.op = OP_SCALE;
      ST_FETCH:     cmd.op = OP_FETCH;
      ST_TERM:      cmd.op = OP_TERM;
      ST_UPDATE:    cmd.op = OP_UPDATE;
      ST_FINISH: begin
        if (can_finish) begin
          cmd.op         = OP_FINISH;
          out_valid_next = 1'b1;
        end
      end
      default:      cmd.op = OP_NONE;
    endcase
  end

endmodule

/* rtl/core/cgid_dp.sv */
// Datapath: config registers, grid memory, axis split, weights and update.
`timescale 1ns / 1ps
module cgid_dp #(
  parameter int MAX_CELLS_X = 32,
  parameter int MAX_CELLS_Y = 32,
  parameter int MAX_PITCH_Z = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  cgid_pkg::cmd_t                    cmd,
  output cgid_pkg::sts_t                    sts,
  input  logic                              cfg_we,
  input  logic [cgid_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                       cfg_data,
  input  logic [cgid_pkg::REQ_W-1:0]        req_type,
  input  logic [cgid_pkg::ADDR_IN_W-1:0]    cell_addr,
  input  logic [cgid_pkg::COORD_W-1:0]      coord_x,
  input  logic [cgid_pkg::COORD_W-1:0]      coord_y,
  input  logic [cgid_pkg::COORD_W-1:0]      coord_z,
  input  logic signed [cgid_pkg::VAL_W-1:0] sample_value,
  output logic signed [cgid_pkg::VAL_W-1:0] result_value,
  output logic [cgid_pkg::STAT_W-1:0]       status
);
  import cgid_pkg::*;

  localparam int GRID_DEPTH = MAX_CELLS_X * MAX_CELLS_Y * MAX_PITCH_Z;
  localparam int ADDR_W = $clog2(GRID_DEPTH);
  localparam int W_W    = FRAC_BITS + 1;
  localparam int P_W    = 2 * W_W;
  localparam int TERM_W = VAL_W + W_W;
  localparam int TX_W   = TERM_W + 1;
  localparam int DEP_W  = TX_W - FRAC_BITS;
  localparam int ACC_W  = TERM_W + 3;
  localparam int AR_W   = ACC_W + 1;
  localparam int ROW_W  = 2 * CFG_CNT_W;
  localparam int GA_W   = CFG_CNT_W + ROW_W;
  localparam int IX_W   = COORD_W + 1;
  localparam logic [31:0] DEPTH_L = 32'(GRID_DEPTH);
  localparam logic [W_W-1:0] ONE_W = W_W'(1) << FRAC_BITS;
  localparam logic [P_W-1:0] HALF_P = P_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [TX_W-1:0] HALF_T = TX_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [AR_W-1:0] HALF_A = AR_W'(1) << (FRAC_BITS - 1);
  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  function automatic logic [CFG_CNT_W-1:0] clamp_cnt(input logic [CFG_CNT_W-1:0] v,
                                                     input int unsigned mx);
    if (32'(v) > mx) return CFG_CNT_W'(mx);
    return v;
  endfunction

  // Configuration registers.
  logic                 periodic_x;
  logic [CFG_CNT_W-1:0] cells_x, cells_y, row_pitch_z;
  logic [COORD_W-1:0]   inv_cell_x, inv_cell_y, inv_cell_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      periodic_x  <= 1'b1;
      cells_x     <= CFG_CNT_W'(32);
      cells_y     <= CFG_CNT_W'(32);
      row_pitch_z <= CFG_CNT_W'(32);
      inv_cell_x  <= 32'd65536;
      inv_cell_y  <= 32'd65536;
      inv_cell_z  <= 32'd65536;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_PERIODIC_X: periodic_x  <= cfg_data[0];
        CFG_CELLS_X:    cells_x     <= cfg_data[CFG_CNT_W-1:0];
        CFG_CELLS_Y:    cells_y     <= cfg_data[CFG_CNT_W-1:0];
        CFG_PITCH_Z:    row_pitch_z <= cfg_data[CFG_CNT_W-1:0];
        CFG_INV_X:      inv_cell_x  <= cfg_data;
        CFG_INV_Y:      inv_cell_y  <= cfg_data;
        CFG_INV_Z:      inv_cell_z  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [CFG_CNT_W-1:0] ncx, ncy, npz;
  assign ncx = clamp_cnt(cells_x, MAX_CELLS_X);
  assign ncy = clamp_cnt(cells_y, MAX_CELLS_Y);
  assign npz = clamp_cnt(row_pitch_z, MAX_PITCH_Z);

  // Request and working registers.
  logic [REQ_W-1:0]         req_r;
  logic [ADDR_IN_W-1:0]     addr_r;
  logic [COORD_W-1:0]       coord_r [3];
  logic signed [VAL_W-1:0]  sval_r;
  logic                     ok_r;
  logic [2*COORD_W-1:0]     prod_r;
  logic [COORD_W-1:0]       idx_r [3];
  logic [FRAC_BITS-1:0]     frac_r [3];
  logic [CFG_CNT_W-1:0]     lo_r [3];
  logic [CFG_CNT_W-1:0]     hi_r [3];
  logic [W_W-1:0]           wxy_r, w_r;
  logic [ROW_W-1:0]         row_r;
  logic [ADDR_W-1:0]        gaddr_r;
  logic signed [TERM_W-1:0] term_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     satd_r;
  logic [ADDR_W-1:0]        clr_cnt;
  logic signed [VAL_W-1:0]  rdata;

  assign sts.clr_done = (clr_cnt == ADDR_W'(GRID_DEPTH - 1));
  assign sts.req      = req_t'(req_r);
  assign sts.ok       = ok_r;

  // Axis split: pick the multiplier operands.
  logic [COORD_W-1:0] inv_sel;
  always_comb begin
    case (cmd.axis)
      AXIS_X:  inv_sel = inv_cell_x;
      AXIS_Y:  inv_sel = inv_cell_y;
      default: inv_sel = inv_cell_z;
    endcase
  end

  // Neighbor indices, x wrap and bounds.
  logic [IX_W-1:0] x_lo, x_hi, x_lo_w, x_hi_w, y_lo, y_hi, z_lo, z_hi;
  logic [IX_W-1:0] ncx_e, ncy_e, npz_e;
  logic            inb;
  always_comb begin
    ncx_e  = IX_W'(ncx);
    ncy_e  = IX_W'(ncy);
    npz_e  = IX_W'(npz);
    x_lo   = IX_W'(idx_r[0]);
    x_hi   = IX_W'(idx_r[0]) + IX_W'(1);
    y_lo   = IX_W'(idx_r[1]);
    y_hi   = IX_W'(idx_r[1]) + IX_W'(1);
    z_lo   = IX_W'(idx_r[2]);
    z_hi   = IX_W'(idx_r[2]) + IX_W'(1);
    x_lo_w = (periodic_x && x_lo >= ncx_e) ? x_lo - ncx_e : x_lo;
    x_hi_w = (periodic_x && x_hi >= ncx_e) ? x_hi - ncx_e : x_hi;
    inb    = (x_lo_w < ncx_e) && (x_hi_w < ncx_e) && (y_lo < ncy_e) && (y_hi < ncy_e) &&
             (z_lo < npz_e) && (z_hi < npz_e);
  end

  // Corner selection, weights and address.
  logic [W_W-1:0]       wx, wy, wz;
  logic [CFG_CNT_W-1:0] xsel, ysel, zsel;
  logic [P_W-1:0]       wxy_full, w_full;
  logic [ROW_W-1:0]     row_c;
  logic [GA_W-1:0]      ga_c;
  always_comb begin
    wx       = cmd.corner[2] ? W_W'(frac_r[0]) : ONE_W - W_W'(frac_r[0]);
    wy       = cmd.corner[1] ? W_W'(frac_r[1]) : ONE_W - W_W'(frac_r[1]);
    wz       = cmd.corner[0] ? W_W'(frac_r[2]) : ONE_W - W_W'(frac_r[2]);
    xsel     = cmd.corner[2] ? hi_r[0] : lo_r[0];
    ysel     = cmd.corner[1] ? hi_r[1] : lo_r[1];
    zsel     = cmd.corner[0] ? hi_r[2] : lo_r[2];
    wxy_full = P_W'(wx) * P_W'(wy) + HALF_P;
    w_full   = P_W'(wxy_r) * P_W'(wz) + HALF_P;
    row_c    = ROW_W'(ysel) + ROW_W'(ncy) * ROW_W'(xsel);
    ga_c     = GA_W'(zsel) + GA_W'(npz) * GA_W'(row_r);
  end

  // Weighted term: cell for interpolate, amount for deposit.
  logic signed [VAL_W-1:0]   op_s;
  logic signed [W_W:0]       w_s;
  logic signed [TERM_W:0]    term_full;
  always_comb begin
    op_s      = (req_t'(req_r) == REQ_INTERP) ? rdata : sval_r;
    w_s       = $signed({1'b0, w_r});
    term_full = op_s * w_s;
  end

  // Deposit update: round, add, saturate.
  logic signed [TX_W-1:0] t_ext, t_sum, t_rnd;
  logic [DEP_W:0]         nv;
  logic                   nv_fits;
  logic [VAL_W-1:0]       nv_sat;
  always_comb begin
    t_ext   = {term_r[TERM_W-1], term_r};
    t_sum   = t_ext + HALF_T;
    t_rnd   = t_sum >>> FRAC_BITS;
    nv      = {t_rnd[DEP_W-1], t_rnd[DEP_W-1:0]} +
              {{(DEP_W+1-VAL_W){rdata[VAL_W-1]}}, rdata};
    nv_fits = (&nv[DEP_W:VAL_W-1]) || !(|nv[DEP_W:VAL_W-1]);
    nv_sat  = nv_fits ? nv[VAL_W-1:0] : (nv[DEP_W] ? VAL_MIN : VAL_MAX);
  end

  // Interpolation result: round, saturate.
  logic signed [AR_W-1:0] a_ext, a_sum, a_rnd;
  logic                   a_fits;
  logic [VAL_W-1:0]       a_sat;
  logic signed [ACC_W-1:0] term_acc;
  always_comb begin
    term_acc = {{(ACC_W-TERM_W){term_r[TERM_W-1]}}, term_r};
    a_ext    = {acc_r[ACC_W-1], acc_r};
    a_sum    = a_ext + HALF_A;
    a_rnd    = a_sum >>> FRAC_BITS;
    a_fits   = (&a_rnd[AR_W-1:VAL_W-1]) || !(|a_rnd[AR_W-1:VAL_W-1]);
    a_sat    = a_fits ? a_rnd[VAL_W-1:0] : (a_rnd[AR_W-1] ? VAL_MIN : VAL_MAX);
  end

  // Final value and status of the request.
  logic signed [VAL_W-1:0] fin_value;
  logic [STAT_W-1:0]       fin_status;
  always_comb begin
    fin_value  = '0;
    fin_status = ok_r ? STAT_OK : STAT_OUTSIDE;
    case (req_t'(req_r))
      REQ_READ:    if (ok_r) fin_value = rdata;
      REQ_INTERP:  if (ok_r) fin_value = $signed(a_sat);
      REQ_DEPOSIT: if (ok_r && satd_r) fin_status = STAT_SATURATED;
      default: ;
    endcase
  end

  // Memory port selection.
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [VAL_W-1:0]  mem_wdata;
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = gaddr_r;
    mem_raddr = gaddr_r;
    mem_wdata = nv_sat;
    case (cmd.op)
      OP_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      OP_WRITE: begin
        mem_we    = ok_r;
        mem_waddr = ADDR_W'(addr_r);
        mem_wdata = sval_r;
      end
      OP_READ: begin
        mem_re    = ok_r;
        mem_raddr = ADDR_W'(addr_r);
      end
      OP_FETCH:  mem_re = 1'b1;
      OP_UPDATE: mem_we = (req_t'(req_r) == REQ_DEPOSIT);
      default: ;
    endcase
  end

  logic [VAL_W-1:0] grid_mem [GRID_DEPTH];
  always_ff @(posedge clk) begin
    if (mem_we) grid_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= grid_mem[mem_raddr];
  end

  // Clear sweep counter.
  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.op == OP_CLEAR) clr_cnt <= clr_cnt + ADDR_W'(1);
  end

  // Working registers per command.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        req_r      <= req_type;
        addr_r     <= cell_addr;
        coord_r[0] <= coord_x;
        coord_r[1] <= coord_y;
        coord_r[2] <= coord_z;
        sval_r     <= sample_value;
        ok_r       <= (32'(cell_addr) < DEPTH_L);
        acc_r      <= '0;
        satd_r     <= 1'b0;
      end
      OP_SPLIT: begin
        prod_r <= (2*COORD_W)'(coord_r[cmd.axis]) * (2*COORD_W)'(inv_sel);
        if (cmd.axis != AXIS_X) begin
          idx_r[cmd.axis - 2'd1]  <= prod_r[2*COORD_W-1:COORD_W];
          frac_r[cmd.axis - 2'd1] <= prod_r[COORD_W-1 -: FRAC_BITS];
        end
      end
      OP_SPLIT_END: begin
        idx_r[2]  <= prod_r[2*COORD_W-1:COORD_W];
        frac_r[2] <= prod_r[COORD_W-1 -: FRAC_BITS];
      end
      OP_CHECK: begin
        ok_r    <= inb;
        lo_r[0] <= x_lo_w[CFG_CNT_W-1:0];
        hi_r[0] <= x_hi_w[CFG_CNT_W-1:0];
        lo_r[1] <= y_lo[CFG_CNT_W-1:0];
        hi_r[1] <= y_hi[CFG_CNT_W-1:0];
        lo_r[2] <= z_lo[CFG_CNT_W-1:0];
        hi_r[2] <= z_hi[CFG_CNT_W-1:0];
      end
      OP_WEIGHT: begin
        wxy_r <= wxy_full[FRAC_BITS +: W_W];
        row_r <= row_c;
      end
      OP_SCALE: begin
        w_r     <= w_full[FRAC_BITS +: W_W];
        gaddr_r <= ADDR_W'(ga_c);
      end
      OP_TERM: term_r <= term_full[TERM_W-1:0];
      OP_UPDATE: begin
        if (req_t'(req_r) == REQ_INTERP) acc_r <= acc_r + term_acc;
        else if (!nv_fits) satd_r <= 1'b1;
      end
      OP_FINISH: begin
        result_value <= fin_value;
        status       <= fin_status;
      end
      default: ;
    endcase
  end

endmodule
